// ----- rtl/core/tcc_pkg.sv -----
// Package for the text console: field widths, character codes, default geometry
// and the structs that pass between the cursor unit and the screen store.
// No dependencies.
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int DEF_COLS  = 80;
  localparam int DEF_ROWS  = 25;

  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = 16;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

  localparam logic MODE_PUT   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic                 cell_written;
    logic [ROW_OUT_W-1:0] cell_row;
    logic [COL_OUT_W-1:0] cell_col;
    logic [CELL_W-1:0]    cell_value;
    logic [ROW_OUT_W-1:0] cursor_row_out;
    logic [COL_OUT_W-1:0] cursor_col_out;
    logic                 scrolled;
  } tcc_result_t;

  typedef struct packed {
    logic go;
    logic clear;
    logic scroll;
    logic put;
  } tcc_cmd_t;

endpackage

// ----- rtl/core/tcc_in_if.sv -----
// Input channel of the text console: one beat carries a mode and a character byte.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

interface tcc_in_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, mode, char_code, input ready);
  modport sink   (input valid, mode, char_code, output ready);
endinterface

// ----- rtl/core/tcc_out_if.sv -----
// Result channel of the text console: one beat per input beat.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

interface tcc_out_if import tcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 cell_written;
  logic [ROW_OUT_W-1:0] cell_row;
  logic [COL_OUT_W-1:0] cell_col;
  logic [CELL_W-1:0]    cell_value;
  logic [ROW_OUT_W-1:0] cursor_row_out;
  logic [COL_OUT_W-1:0] cursor_col_out;
  logic                 scrolled;

  modport source (output valid, cell_written, cell_row, cell_col, cell_value,
                  cursor_row_out, cursor_col_out, scrolled, input ready);
  modport sink   (input valid, cell_written, cell_row, cell_col, cell_value,
                  cursor_row_out, cursor_col_out, scrolled, output ready);
endinterface

// ----- rtl/core/tcc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/tcc_cursor.sv -----
// Cursor unit: holds the cursor, works out each beat's result and the store command.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_cursor import tcc_pkg::*; #(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          mode,
  input  logic [CHAR_W-1:0]             char_code,
  input  logic [ATTR_W-1:0]             attr,
  output tcc_result_t                   result,
  output tcc_cmd_t                      cmd,
  output logic [$clog2(ROWS*COLS)-1:0]  cmd_addr,
  output logic [CELL_W-1:0]             cmd_data
);

  localparam int RW = $clog2(ROWS + 1);
  localparam int CW = $clog2(COLS + 1);
  localparam int AW = $clog2(ROWS * COLS);
  localparam logic [RW-1:0] ROW_END  = RW'(ROWS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_END  = CW'(COLS);

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] r1;
  logic [CW-1:0] c1;
  logic          scroll;

  always_comb begin
    r1       = row_r;
    c1       = col_r;
    scroll   = 1'b0;
    row_nxt  = row_r;
    col_nxt  = col_r;
    cmd      = '0;
    result   = '0;
    cmd_data = {attr, char_code};
    cmd_addr = '0;
    if (mode == MODE_CLEAR) begin
      row_nxt   = '0;
      col_nxt   = '0;
      cmd.clear = 1'b1;
    end else if (char_code == NEWLINE_CHAR) begin
      r1 = row_r + RW'(1);
      c1 = '0;
      if (r1 >= ROW_END) begin
        r1     = ROW_LAST;
        scroll = 1'b1;
      end
      row_nxt = r1;
      col_nxt = '0;
    end else begin
      if (col_r >= COL_END) begin
        c1 = '0;
        r1 = row_r + RW'(1);
      end
      if (r1 >= ROW_END) begin
        r1     = ROW_LAST;
        c1     = '0;
        scroll = 1'b1;
      end
      row_nxt             = r1;
      col_nxt             = c1 + CW'(1);
      cmd.put             = 1'b1;
      cmd_addr            = AW'(r1 * COLS) + AW'(c1);
      result.cell_written = 1'b1;
      result.cell_row     = ROW_OUT_W'(r1);
      result.cell_col     = COL_OUT_W'(c1);
      result.cell_value   = {attr, char_code};
    end
    cmd.go                = accept;
    cmd.scroll            = scroll;
    result.scrolled       = scroll;
    result.cursor_row_out = ROW_OUT_W'(row_nxt);
    result.cursor_col_out = COL_OUT_W'(col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < ROW_END) && (col_r <= COL_END))
    else $error("cursor left the screen");

endmodule

// ----- rtl/core/tcc_store.sv -----
// Screen store: the cell RAM and the sequencer that clears it after reset, writes
// characters, scrolls one row up and fills the screen. Depends on tcc_pkg, tcc_ram.
`timescale 1ns / 1ps

module tcc_store import tcc_pkg::*; #(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcc_cmd_t                      cmd,
  input  logic [$clog2(ROWS*COLS)-1:0]  cmd_addr,
  input  logic [CELL_W-1:0]             cmd_data,
  input  logic [ATTR_W-1:0]             attr,
  output logic                          idle
);

  localparam int N  = ROWS * COLS;
  localparam int AW = $clog2(N);
  localparam logic [AW-1:0] LAST      = AW'(N - 1);
  localparam logic [AW-1:0] COPY_LAST = AW'(N - COLS - 1);
  localparam logic [AW-1:0] BOTTOM    = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic              cp_v_r, cp_v_nxt;
  logic [AW-1:0]     cp_addr_r, cp_addr_nxt;
  logic              pend_put_r, pend_put_nxt;
  logic [CELL_W-1:0] pend_data_r, pend_data_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic [CELL_W-1:0] blank;

  assign blank     = {attr, SPACE_CHAR};
  assign ram_raddr = ptr_r + ROW_STEP;
  assign idle      = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cp_v_nxt      = 1'b0;
    cp_addr_nxt   = cp_addr_r;
    pend_put_nxt  = pend_put_r;
    pend_data_nxt = pend_data_r;
    ram_we        = cp_v_r;
    ram_waddr     = cp_addr_r;
    ram_wdata     = ram_rdata;
    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = '0;
        if (ptr_r == LAST) begin
          state_nxt = S_IDLE;
          ptr_nxt   = '0;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (cmd.go) begin
          if (cmd.clear) begin
            state_nxt = S_CLEAR;
            ptr_nxt   = '0;
          end else if (cmd.scroll) begin
            state_nxt     = S_COPY;
            ptr_nxt       = '0;
            pend_put_nxt  = cmd.put;
            pend_data_nxt = cmd_data;
          end else if (cmd.put) begin
            ram_we    = 1'b1;
            ram_waddr = cmd_addr;
            ram_wdata = cmd_data;
          end
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = blank;
        if (ptr_r == LAST) begin
          state_nxt = S_IDLE;
          ptr_nxt   = '0;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_COPY: begin
        cp_v_nxt    = 1'b1;
        cp_addr_nxt = ptr_r;
        if (ptr_r == COPY_LAST) begin
          state_nxt = S_FILL;
          ptr_nxt   = BOTTOM;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_FILL: begin
        if (!cp_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_r;
          ram_wdata = (pend_put_r && (ptr_r == BOTTOM)) ? pend_data_r : blank;
          if (ptr_r == LAST) begin
            state_nxt    = S_IDLE;
            ptr_nxt      = '0;
            pend_put_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        ptr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      ptr_r      <= '0;
      cp_v_r     <= 1'b0;
      pend_put_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      cp_v_r     <= cp_v_nxt;
      pend_put_r <= pend_put_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r   <= cp_addr_nxt;
    pend_data_r <= pend_data_nxt;
  end

  tcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (N)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_copy_only_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    cp_v_r |-> (state_r == S_COPY || state_r == S_FILL))
    else $error("row copy write outside a scroll");

  a_copy_feeds_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |=> cp_v_r)
    else $error("row copy read without a following write");

  a_fill_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && !cp_v_r) |-> (ptr_r >= BOTTOM))
    else $error("bottom row fill outside the bottom row");

endmodule

// ----- rtl/core/text_console_cursor_scroll.sv -----
// Text console top level: a ROWS x COLS store of 16-bit cells (attribute high byte,
// character low byte), a cursor and one result beat per input beat. After reset the
// store is zeroed by a pass over every cell during which no input beat is taken;
// attribute writes are taken at any time. A character or newline that does not
// scroll leaves the store idle. A beat that scrolls occupies the store's single
// write port while rows are copied up one cell per cycle, then the bottom row filled,
// and a clear fills every cell with a blank; no beat is taken meanwhile. The result of
// a beat is registered at its acceptance; no new beat is taken while it waits, and the
// next beat can be taken at the earliest in the cycle in which the result is delivered.
// Depends on tcc_pkg, tcc_in_if, tcc_out_if, tcc_cursor, tcc_store.
`timescale 1ns / 1ps

module text_console_cursor_scroll import tcc_pkg::*; #(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata,
  tcc_in_if.sink            in_bus,
  tcc_out_if.source         out_bus
);

  localparam int AW = $clog2(ROWS * COLS);

  logic [ATTR_W-1:0] attr_r;
  logic              out_valid_r;
  tcc_result_t       res_r;
  tcc_result_t       result;
  tcc_cmd_t          cmd;
  logic [AW-1:0]     cmd_addr;
  logic [CELL_W-1:0] cmd_data;
  logic              store_idle;
  logic              accept;

  assign in_bus.ready = store_idle && (!out_valid_r || out_bus.ready);
  assign accept       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  tcc_cursor #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .mode      (in_bus.mode),
    .char_code (in_bus.char_code),
    .attr      (attr_r),
    .result    (result),
    .cmd       (cmd),
    .cmd_addr  (cmd_addr),
    .cmd_data  (cmd_data)
  );

  tcc_store #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cmd_addr (cmd_addr),
    .cmd_data (cmd_data),
    .attr     (attr_r),
    .idle     (store_idle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= result;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.cell_written   = res_r.cell_written;
  assign out_bus.cell_row       = res_r.cell_row;
  assign out_bus.cell_col       = res_r.cell_col;
  assign out_bus.cell_value     = res_r.cell_value;
  assign out_bus.cursor_row_out = res_r.cursor_row_out;
  assign out_bus.cursor_col_out = res_r.cursor_col_out;
  assign out_bus.scrolled       = res_r.scrolled;

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");

endmodule
